@@ hw/rtl/u8d_pkg.sv @@
// ----------------------------------------------------------------------------
// u8d_pkg
// Shared types and byte constants for the UTF-8 code point decoder.
// ----------------------------------------------------------------------------
package u8d_pkg;

    localparam int MAX_RESULTS = 4;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

    // Lead bytes with a tightened first continuation range, and the lowest legal lead
    localparam logic [7:0] LEAD_E0   = 8'hE0;
    localparam logic [7:0] LEAD_ED   = 8'hED;
    localparam logic [7:0] LEAD_F0   = 8'hF0;
    localparam logic [7:0] LEAD_F4   = 8'hF4;
    localparam logic [7:0] LEAD_MIN  = 8'hC2;

    // Continuation bounds
    localparam logic [7:0] CONT_MIN  = 8'h80;
    localparam logic [7:0] CONT_MAX  = 8'hBF;
    localparam logic [7:0] CONT_A0   = 8'hA0;
    localparam logic [7:0] CONT_9F   = 8'h9F;
    localparam logic [7:0] CONT_90   = 8'h90;
    localparam logic [7:0] CONT_8F   = 8'h8F;

    localparam logic [7:0] ASCII_MIN = 8'h01;
    localparam logic [7:0] ASCII_MAX = 8'h7F;
    localparam logic [5:0] CONT_MASK = 6'h3F;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_text;
    } byte_item_t;

    typedef struct packed {
        logic [20:0] code_point;
        logic [2:0]  byte_count;
        logic        was_illegal;
        logic        run_last;
    } cp_item_t;

    typedef struct packed {
        logic [7:0]       lead_value;
        logic [2:0]       expected_length;
        logic [1:0]       received_count;
        logic [1:0][7:0]  held_continuations;
        logic [20:0]      partial_point;
    } seq_state_t;

endpackage

@@ hw/rtl/u8d_step.sv @@
// ----------------------------------------------------------------------------
// u8d_step
// Combinational decode of one byte against the open sequence state.
// ----------------------------------------------------------------------------
module u8d_step (
    input  u8d_pkg::seq_state_t                   cur,
    input  u8d_pkg::byte_item_t                   item,
    output u8d_pkg::seq_state_t                   nxt,
    output logic [u8d_pkg::CNT_W-1:0]             num,
    output u8d_pkg::cp_item_t [u8d_pkg::MAX_RESULTS-1:0] res
);
    import u8d_pkg::*;

    logic [7:0]       b;
    logic             eot;
    logic             open_seq;
    logic [7:0]       lo;
    logic [7:0]       hi;
    logic             ok;
    logic             complete;
    logic [20:0]      acc;
    logic             flush;
    logic [CNT_W-1:0] nflush;
    logic             fresh;
    logic             is_lead;
    logic             is_ascii;
    logic             tail_emit;
    cp_item_t         tail;
    cp_item_t         raw_item;
    seq_state_t       closed;

    always_comb
    begin
        b        = item.data_byte;
        eot      = item.end_of_text;
        open_seq = (cur.expected_length != 3'd0);
        closed   = '0;

        // First continuation ranges depend on the lead byte
        lo = CONT_MIN;
        hi = CONT_MAX;
        if (cur.received_count == 2'd0)
        begin
            priority if (cur.lead_value == LEAD_E0) lo = CONT_A0;
            else if (cur.lead_value == LEAD_ED)     hi = CONT_9F;
            else if (cur.lead_value == LEAD_F0)     lo = CONT_90;
            else if (cur.lead_value == LEAD_F4)     hi = CONT_8F;
            else                                    lo = CONT_MIN;
        end
        ok       = open_seq && (b >= lo) && (b <= hi);
        complete = ({1'b0, cur.received_count} + 3'd2) >= cur.expected_length;
        acc      = {cur.partial_point[14:0], b[5:0] & CONT_MASK};

        flush  = open_seq && (!ok || (!complete && eot));
        nflush = flush ? (CNT_W'(cur.received_count) + CNT_W'(1)) : '0;
        // Byte is handled as a fresh byte when no sequence accepts it
        fresh    = !ok;
        is_lead  = (b >= LEAD_MIN) && (b <= LEAD_F4);
        is_ascii = (b >= ASCII_MIN) && (b <= ASCII_MAX);

        raw_item             = '0;
        raw_item.code_point  = {13'd0, b};
        raw_item.byte_count  = 3'd1;
        raw_item.was_illegal = 1'b1;

        tail      = raw_item;
        tail_emit = 1'b0;
        nxt       = cur;

        if (ok && complete)
        begin
            tail             = '0;
            tail.code_point  = acc;
            tail.byte_count  = cur.expected_length;
            tail_emit        = 1'b1;
            nxt              = closed;
        end
        else if (ok && eot)
        begin
            tail_emit = 1'b1;
            nxt       = closed;
        end
        else if (ok)
        begin
            nxt.held_continuations[cur.received_count[0]] = b;
            nxt.received_count = cur.received_count + 2'd1;
            nxt.partial_point  = acc;
        end

        if (fresh)
        begin
            nxt = closed;
            if (is_ascii)
            begin
                tail.was_illegal = 1'b0;
                tail_emit        = 1'b1;
            end
            else if (is_lead && !eot)
            begin
                nxt.lead_value = b;
                priority if (b < LEAD_E0)
                begin
                    nxt.expected_length = 3'd2;
                    nxt.partial_point   = {16'd0, b[4:0]};
                end
                else if (b < LEAD_F0)
                begin
                    nxt.expected_length = 3'd3;
                    nxt.partial_point   = {17'd0, b[3:0]};
                end
                else
                begin
                    nxt.expected_length = 3'd4;
                    nxt.partial_point   = {18'd0, b[2:0]};
                end
            end
            else
            begin
                tail_emit = 1'b1;
            end
        end

        num = nflush + (tail_emit ? CNT_W'(1) : '0);

        // Lay out flushed bytes first, then the tail item
        for (int i = 0; i < MAX_RESULTS; i++)
        begin
            res[i] = tail;
            if (CNT_W'(i) < nflush)
            begin
                res[i] = raw_item;
                if (i == 0)
                    res[i].code_point = {13'd0, cur.lead_value};
                else
                    res[i].code_point = {13'd0, cur.held_continuations[1'(i + 1)]};
            end
            res[i].run_last = (CNT_W'(i) + CNT_W'(1)) == num;
        end
    end

endmodule

@@ hw/rtl/utf8_codepoint_decoder.sv @@
// ----------------------------------------------------------------------------
// utf8_codepoint_decoder
// Output: the first item of an accepted byte is registered and shows in the cycle after.
// Throughput: one byte per cycle while each byte yields at most one item and
//   the output does not stall; a byte that yields more than one item holds the
//   input while the result list drains through the single output port.
// Reset: rst_n clears the open sequence and empties the result list.
// ----------------------------------------------------------------------------
module utf8_codepoint_decoder (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 byte_valid,
    output logic                 byte_ready,
    input  u8d_pkg::byte_item_t  byte_item,
    output logic                 cp_valid,
    input  logic                 cp_ready,
    output u8d_pkg::cp_item_t    cp_item
);
    import u8d_pkg::*;

    // Open sequence: lead byte, length, held continuation bytes, partial bits
    seq_state_t                      seq_reg;
    seq_state_t                      seq_next;

    // Result list: entry 0 drives the output, later entries shift down
    cp_item_t [MAX_RESULTS-1:0]      list_reg;
    cp_item_t [MAX_RESULTS-1:0]      list_next;
    logic [CNT_W-1:0]                cnt_reg;
    logic [CNT_W-1:0]                cnt_next;

    cp_item_t [MAX_RESULTS-1:0]      step_res;
    logic [CNT_W-1:0]                step_num;
    logic                            in_fire;
    logic                            out_fire;

    u8d_step u_step (
        .cur  (seq_reg),
        .item (byte_item),
        .nxt  (seq_next),
        .num  (step_num),
        .res  (step_res)
    );

    assign cp_valid = (cnt_reg != '0);
    assign cp_item  = list_reg[0];
    assign out_fire = cp_valid && cp_ready;
    // Take a new byte once the list is empty or its last item leaves now
    assign byte_ready = (cnt_reg == '0) || ((cnt_reg == CNT_W'(1)) && cp_ready);
    assign in_fire    = byte_valid && byte_ready;

    always_comb
    begin
        list_next = list_reg;
        cnt_next  = cnt_reg;
        if (in_fire)
        begin
            // Load the full result set of this byte at once
            list_next = step_res;
            cnt_next  = step_num;
        end
        else if (out_fire)
        begin
            // Advance the list by one item
            for (int i = 0; i < MAX_RESULTS - 1; i++)
                list_next[i] = list_reg[i + 1];
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (in_fire)
                seq_reg <= seq_next;
        end
    end

    // Payload only, no reset needed
    always_ff @(posedge clk)
    begin
        list_reg <= list_next;
    end

endmodule

@@ hw/rtl/u8d_checker.sv @@
// ----------------------------------------------------------------------------
// u8d_checker
// Port-level checks on the decoder, bound to the top level.
// ----------------------------------------------------------------------------
module u8d_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 byte_valid,
    input logic                 byte_ready,
    input u8d_pkg::byte_item_t  byte_item,
    input logic                 cp_valid,
    input logic                 cp_ready,
    input u8d_pkg::cp_item_t    cp_item
);
    import u8d_pkg::*;

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        cp_valid && !cp_ready |=> cp_valid && $stable(cp_item))
        else $error("stalled result item changed or dropped");

    // Drop input ready while the output stalls
    a_stall_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
        cp_valid && !cp_ready |-> !byte_ready)
        else $error("byte taken while result stalled");

    // More items of the same byte still pending: no new byte
    a_run_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
        cp_valid && !cp_item.run_last |-> !byte_ready)
        else $error("byte taken in the middle of a result run");

    // Raw bytes carry a count of one
    a_raw_count: assert property (@(posedge clk) disable iff (!rst_n)
        cp_valid && cp_item.was_illegal |-> cp_item.byte_count == 3'd1)
        else $error("illegal item with count other than one");

    // Legal single-byte items are ASCII, multi-byte counts stay in range
    a_legal_range: assert property (@(posedge clk) disable iff (!rst_n)
        cp_valid && !cp_item.was_illegal |->
            (cp_item.byte_count == 3'd2 || cp_item.byte_count == 3'd3 ||
             cp_item.byte_count == 3'd4 ||
             (cp_item.byte_count == 3'd1 && cp_item.code_point != 21'd0 &&
              cp_item.code_point[20:7] == 14'd0)))
        else $error("legal item out of range");

endmodule

bind utf8_codepoint_decoder u8d_checker u_u8d_checker (.*);

@@ sim/tb_utf8_codepoint_decoder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_utf8_codepoint_decoder
// Streams UTF-8 bytes into the decoder and checks every code point item
// against a predictor of the well-formed decoding rules, with random idling
// on both sides.
// ----------------------------------------------------------------------------
module tb_utf8_codepoint_decoder;

    import u8d_pkg::*;

    // Generous bound: every byte with four results, each behind a long stall
    localparam int CYCLE_LIMIT = 200000;
    // Cycles to watch for stray items once nothing is expected
    localparam int SETTLE_CYCLES = 8;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       byte_valid = 1'b0;
    logic       byte_ready;
    byte_item_t byte_item = '0;
    logic       cp_valid;
    logic       cp_ready = 1'b0;
    cp_item_t   cp_item;

    utf8_codepoint_decoder dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_ready (byte_ready),
        .byte_item  (byte_item),
        .cp_valid   (cp_valid),
        .cp_ready   (cp_ready),
        .cp_item    (cp_item)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Predictor state: the sequence currently open in the decoder
    // ------------------------------------------------------------------------
    logic [7:0]  open_lead;
    logic [2:0]  open_len;      // 0 when no sequence is open
    logic [1:0]  open_got;      // continuation bytes held so far
    logic [7:0]  open_held [2];
    logic [20:0] open_bits;

    cp_item_t    expected_points [$];   // code points still owed by the block
    cp_item_t    step_points [$];       // code points caused by one byte
    cp_item_t    want;
    int          error_count = 0;
    int          bytes_sent = 0;
    int          cycle_count = 0;
    logic        idle_off = 1'b0;       // when set, neither side idles

    function automatic void close_open();
        open_lead    = '0;
        open_len     = '0;
        open_got     = '0;
        open_held[0] = '0;
        open_held[1] = '0;
        open_bits    = '0;
    endfunction

    function automatic void emit_point(logic [20:0] cp, logic [2:0] cnt, logic ill);
        cp_item_t p;
        p.code_point  = cp;
        p.byte_count  = cnt;
        p.was_illegal = ill;
        p.run_last    = 1'b0;
        step_points.push_back(p);
    endfunction

    // Replay the open sequence raw: lead first, then each held continuation
    function automatic void flush_open();
        emit_point({13'd0, open_lead}, 3'd1, 1'b1);
        for (int i = 0; i < open_got && i < 2; i++)
            emit_point({13'd0, open_held[i]}, 3'd1, 1'b1);
    endfunction

    // Advance the predictor by one accepted byte and queue what it yields
    function automatic void decode_utf8_byte(logic [7:0] b, logic eot);
        logic [7:0]  lo;
        logic [7:0]  hi;
        logic [2:0]  pos;
        logic [20:0] acc;
        logic        taken;
        taken = 1'b0;
        step_points.delete();
        if (open_len != 0)
        begin
            pos = {1'b0, open_got} + 3'd1;
            lo  = CONT_MIN;
            hi  = CONT_MAX;
            // Only the first continuation has a lead-specific range
            if (pos == 3'd1)
            begin
                case (open_lead)
                    LEAD_E0: lo = CONT_A0;
                    LEAD_ED: hi = CONT_9F;
                    LEAD_F0: lo = CONT_90;
                    LEAD_F4: hi = CONT_8F;
                    default: ;
                endcase
            end
            if (b >= lo && b <= hi)
            begin
                taken = 1'b1;
                acc   = {open_bits[14:0], b[5:0]};
                if (pos + 3'd1 >= open_len)
                begin
                    emit_point(acc, open_len, 1'b0);
                    close_open();
                end
                else if (eot)
                begin
                    // Text ends inside the sequence: everything goes out raw
                    flush_open();
                    emit_point({13'd0, b}, 3'd1, 1'b1);
                    close_open();
                end
                else
                begin
                    open_held[open_got[0]] = b;
                    open_got  = open_got + 2'd1;
                    open_bits = acc;
                end
            end
            else
            begin
                // Bad continuation: replay raw, then treat this byte afresh
                flush_open();
                close_open();
            end
        end
        if (!taken)
        begin
            if (b >= ASCII_MIN && b <= ASCII_MAX)
                emit_point({13'd0, b}, 3'd1, 1'b0);
            else if (b >= LEAD_MIN && b <= LEAD_F4)
            begin
                if (eot)
                    emit_point({13'd0, b}, 3'd1, 1'b1);
                else
                begin
                    open_lead = b;
                    open_got  = '0;
                    if (b < LEAD_E0)
                    begin
                        open_len  = 3'd2;
                        open_bits = {16'd0, b[4:0]};
                    end
                    else if (b < LEAD_F0)
                    begin
                        open_len  = 3'd3;
                        open_bits = {17'd0, b[3:0]};
                    end
                    else
                    begin
                        open_len  = 3'd4;
                        open_bits = {18'd0, b[2:0]};
                    end
                end
            end
            else
                emit_point({13'd0, b}, 3'd1, 1'b1);
        end
        if (step_points.size() > 0)
            step_points[step_points.size() - 1].run_last = 1'b1;
        foreach (step_points[i])
            expected_points.push_back(step_points[i]);
    endfunction

    // Mostly no gap, sometimes a few cycles, rarely a long one
    function automatic int pick_gap();
        int r;
        if (idle_off)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // ------------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------------

    // Present one byte and hold it until accepted. Valid stays high on return
    // so a back-to-back byte can follow in the same step without a dip.
    task automatic send_byte(input logic [7:0] b, input logic eot);
        byte_item_t item;
        int         gap;
        item.data_byte   = b;
        item.end_of_text = eot;
        gap = pick_gap();
        if (gap > 0)
        begin
            byte_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        byte_valid <= 1'b1;
        byte_item  <= item;
        do
            @(posedge clk);
        while (!byte_ready);
        decode_utf8_byte(b, eot);
        bytes_sent++;
    endtask

    task automatic send_run(input logic [7:0] run_bytes [$], input logic eot_last);
        foreach (run_bytes[i])
            send_byte(run_bytes[i], eot_last && (i == run_bytes.size() - 1));
    endtask

    // Drop valid and hold off until every owed code point has come back
    task automatic wait_results_drained();
        byte_valid <= 1'b0;
        while (expected_points.size() != 0)
            @(posedge clk);
    endtask

    // One random run: mostly well-formed sequences, some noise and breakage
    task automatic send_random_run();
        logic [7:0] run_bytes [$];
        logic [7:0] lead;
        logic [7:0] lo;
        logic [7:0] hi;
        int         kind;
        int         len;
        int         pick;
        logic       eot_last;
        kind     = $urandom_range(0, 99);
        eot_last = ($urandom_range(0, 9) == 0);
        if (kind < 30)
            run_bytes.push_back(8'($urandom_range(ASCII_MIN, ASCII_MAX)));
        else if (kind < 40)
            run_bytes.push_back(8'($urandom_range(0, 255)));
        else
        begin
            len  = (kind < 55) ? 2 : (kind < 70) ? 3 : (kind < 85) ? 4 :
                   $urandom_range(2, 4);
            pick = $urandom_range(0, 3);
            if (len == 2)
                lead = 8'($urandom_range(LEAD_MIN, LEAD_E0 - 1));
            else if (len == 3)
                lead = (pick == 0) ? LEAD_E0 : (pick == 1) ? LEAD_ED :
                       8'($urandom_range(LEAD_E0, LEAD_F0 - 1));
            else
                lead = (pick == 0) ? LEAD_F0 : (pick == 1) ? LEAD_F4 :
                       8'($urandom_range(LEAD_F0, LEAD_F4));
            run_bytes.push_back(lead);
            lo = CONT_MIN;
            hi = CONT_MAX;
            case (lead)
                LEAD_E0: lo = CONT_A0;
                LEAD_ED: hi = CONT_9F;
                LEAD_F0: lo = CONT_90;
                LEAD_F4: hi = CONT_8F;
                default: ;
            endcase
            run_bytes.push_back(8'($urandom_range(lo, hi)));
            for (int i = 2; i < len; i++)
                run_bytes.push_back(8'($urandom_range(CONT_MIN, CONT_MAX)));
            // Break the tail of the sequences: corrupt a byte or cut short
            if (kind >= 85)
            begin
                if ($urandom_range(0, 1) == 0)
                    run_bytes[$urandom_range(1, len - 1)] = 8'($urandom_range(0, 255));
                else
                begin
                    while (run_bytes.size() > $urandom_range(1, len - 1))
                        void'(run_bytes.pop_back());
                    eot_last = 1'b1;
                end
            end
        end
        send_run(run_bytes, eot_last);
    endtask

    // ------------------------------------------------------------------------
    // Receiver side: random stalls, and the checker
    // ------------------------------------------------------------------------
    initial
    begin
        int gap;
        forever
        begin
            gap = pick_gap();
            if (gap > 0)
            begin
                cp_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            cp_ready <= 1'b1;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && cp_valid && cp_ready)
        begin
            if (expected_points.size() == 0)
            begin
                $error("unexpected code point item: code_point %0h byte_count %0d",
                       cp_item.code_point, cp_item.byte_count);
                error_count++;
            end
            else
            begin
                want = expected_points.pop_front();
                if (cp_item.code_point !== want.code_point)
                begin
                    $error("code_point: expected %0h, got %0h",
                           want.code_point, cp_item.code_point);
                    error_count++;
                end
                if (cp_item.byte_count !== want.byte_count)
                begin
                    $error("byte_count: expected %0d, got %0d",
                           want.byte_count, cp_item.byte_count);
                    error_count++;
                end
                if (cp_item.was_illegal !== want.was_illegal)
                begin
                    $error("was_illegal: expected %0b, got %0b",
                           want.was_illegal, cp_item.was_illegal);
                    error_count++;
                end
                if (cp_item.run_last !== want.run_last)
                begin
                    $error("run_last: expected %0b, got %0b",
                           want.run_last, cp_item.run_last);
                    error_count++;
                end
            end
        end
    end

    // Hang guard
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d code points still owed",
                     cycle_count, expected_points.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // NUL, the top ASCII byte, a stray continuation, overlong and out-of-range leads
    task automatic test_lone_bytes();
        send_byte(8'h00, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'h80, 1'b1);
        send_byte(8'hC1, 1'b0);
        send_byte(8'hF5, 1'b0);
        send_byte(8'hFF, 1'b1);
    endtask

    // Complete sequences, two of them at the tight first-continuation bounds
    task automatic test_complete_sequences();
        send_run('{8'hC2, 8'h80}, 1'b0);
        send_run('{8'hE0, 8'hA0, 8'h80}, 1'b0);
        send_run('{8'hF4, 8'h8F, 8'hBF, 8'hBF}, 1'b1);
    endtask

    // Bad continuations, early end of text and a lead at end of text
    task automatic test_broken_sequences();
        // ED A0 would be a surrogate: lead raw, then A0 raw on its own
        send_run('{8'hED, 8'hA0}, 1'b0);
        // Two held bytes and an illegal breaker: four raw items at once
        send_run('{8'hF0, 8'h90, 8'h80, 8'hFF}, 1'b0);
        // Text ends one byte short
        send_run('{8'hE1, 8'h80}, 1'b1);
        send_byte(8'hC2, 1'b1);
    endtask

    task automatic test_random_text(input int n);
        int stop_at;
        stop_at = bytes_sent + n;
        while (bytes_sent < stop_at)
            send_random_run();
    endtask

    // Sender pauses mid-stream until the block has fully drained
    task automatic test_pause_until_drained();
        repeat (3) send_random_run();
        send_run('{8'hF3, 8'hBF, 8'hBF}, 1'b0);
        wait_results_drained();
        repeat (3) send_random_run();
    endtask

    // Neither side idles: full-rate bytes under replay back-pressure
    task automatic test_back_to_back(input int n);
        idle_off = 1'b1;
        test_random_text(n);
        idle_off = 1'b0;
    endtask

    initial
    begin
        close_open();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_lone_bytes();
        test_complete_sequences();
        test_broken_sequences();
        test_random_text(40);
        test_pause_until_drained();
        test_back_to_back(25);

        wait_results_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/u8d_pkg.sv
hw/rtl/u8d_step.sv
hw/rtl/utf8_codepoint_decoder.sv
hw/rtl/u8d_checker.sv
sim/tb_utf8_codepoint_decoder.sv
